// File: rtl/core/oele_pkg.sv
// Shared types and constants for the ordered entry list engine.
// Used by oele_cell and ordered_entry_list_engine_core; depends on nothing.
package oele_pkg;

	// Number of cells in the list.
	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 5;
	localparam int FP_W = 4;
	localparam int LEN_W = 5;
	// Width used when positions, cell indexes and the count are compared.
	localparam int CW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	// One stored entry; duration sits in the lowest bits.
	typedef struct packed {
		logic [15:0] timer;
		logic [7:0]  kind;
		logic [7:0]  dropoff;
		logic [7:0]  pickup;
		logic [15:0] duration;
	} entry_t;

	typedef enum logic [2:0] {
		REQ_INSERT    = 3'd0,
		REQ_DELETE    = 3'd1,
		REQ_READ      = 3'd2,
		REQ_WRITE     = 3'd3,
		REQ_FIND_EXACT = 3'd4,
		REQ_FIND_PICK = 3'd5,
		REQ_FIND_DROP = 3'd6,
		REQ_UNUSED    = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_FULL      = 2'd2,
		STS_BAD_POS   = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EVAL
	} state_t;

	// Request as it is broadcast to every cell.
	typedef struct packed {
		req_t             kind;
		logic [POS_W-1:0] pos;
		entry_t           val;
	} req_bus_t;

	// Update command broadcast to every cell at commit.
	typedef struct packed {
		logic     upd;
		req_bus_t req;
	} cell_ctl_t;

endpackage

// File: rtl/core/oele_cell.sv
// One list cell: holds an entry, compares it against a search key, and
// shifts to or from its neighbors. Depends on oele_pkg.
module oele_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [oele_pkg::IDX_W-1:0] idx,
	input  logic [oele_pkg::CNT_W-1:0] count,
	input  logic                     key_load,
	input  oele_pkg::req_bus_t       key,
	input  oele_pkg::cell_ctl_t      ctl,
	input  oele_pkg::entry_t         left_data,
	input  oele_pkg::entry_t         right_data,
	input  logic                     seen_in,
	output oele_pkg::entry_t         data,
	output logic                     seen_out,
	output logic                     sel
);

	oele_pkg::entry_t data_q;
	logic             hit_q;
	logic             hit_d;
	logic             live;
	logic             pos_eq;
	logic             pos_ge;

	assign live = oele_pkg::CW'(idx) < oele_pkg::CW'(count);
	assign pos_eq = oele_pkg::CW'(idx) == oele_pkg::CW'(ctl.req.pos);
	assign pos_ge = oele_pkg::CW'(idx) >= oele_pkg::CW'(ctl.req.pos);

	// Key compare against the stored entry, taken when a request arrives.
	always_comb begin
		case (key.kind)
			oele_pkg::REQ_FIND_EXACT: begin
				hit_d = (data_q.duration == key.val.duration) &&
					(data_q.pickup == key.val.pickup) &&
					(data_q.dropoff == key.val.dropoff) &&
					(data_q.kind == key.val.kind);
			end
			oele_pkg::REQ_FIND_PICK: hit_d = data_q.pickup == key.val.pickup;
			oele_pkg::REQ_FIND_DROP: hit_d = data_q.dropoff == key.val.dropoff;
			default: hit_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (key_load) begin
			hit_q <= hit_d && live;
		end
	end

	// The first hit along the chain wins; position requests pick by index.
	assign seen_out = seen_in | hit_q;
	always_comb begin
		case (ctl.req.kind)
			oele_pkg::REQ_FIND_EXACT,
			oele_pkg::REQ_FIND_PICK,
			oele_pkg::REQ_FIND_DROP: sel = hit_q & ~seen_in;
			default: sel = pos_eq;
		endcase
	end

	// Entry update: load the new entry, or shift from a neighbor.
	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			case (ctl.req.kind)
				oele_pkg::REQ_INSERT: begin
					if (pos_eq) begin
						data_q <= ctl.req.val;
					end else if (pos_ge) begin
						data_q <= left_data;
					end
				end
				oele_pkg::REQ_DELETE: begin
					if (pos_ge) begin
						data_q <= right_data;
					end
				end
				oele_pkg::REQ_WRITE: begin
					if (pos_eq) begin
						data_q <= ctl.req.val;
					end
				end
				default: ;
			endcase
		end
	end

	assign data = data_q;

endmodule

// File: rtl/core/ordered_entry_list_engine_core.sv
// Top level of the ordered entry list engine: request register, control,
// cell chain and result register. Depends on oele_pkg and oele_cell.
//
// Channel  Dir  Bits  Carries
// s_*      in   64    one request per transfer
// m_*      out  72    one result per request
//
// Each request passes through the accept cycle, in which every cell
// compares its entry with the key, and the evaluate state, in which the
// priority pick down the cell chain, the shift of the cells and the result
// register are resolved together. The next request is taken in the cycle
// after the result is registered. A stalled result holds the engine in the
// evaluate state until the output register frees. Reset clears the entry
// count and all control state; the cells' contents are left as they are.
module ordered_entry_list_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// req_type[2:0], position[7:3], duration[23:8], pickup_point[31:24],
	// dropoff_point[39:32], item_kind[47:40], remaining_time[63:48]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], found_position[5:2], out_duration[21:6], out_pickup[29:22],
	// out_dropoff[37:30], out_kind[45:38], out_time[61:46],
	// list_length[66:62], zero[71:67]
	output logic [71:0] m_tdata
);

	localparam int D = oele_pkg::DEPTH;

	oele_pkg::state_t    state_q;
	oele_pkg::state_t    state_d;
	oele_pkg::req_bus_t  key;
	oele_pkg::req_bus_t  req_q;
	oele_pkg::cell_ctl_t ctl;
	logic [oele_pkg::CNT_W-1:0] count_q;
	logic [oele_pkg::CNT_W-1:0] count_d;
	logic                accept;
	logic                commit;
	logic                ok;
	logic                show_entry;
	logic                show_index;
	oele_pkg::status_t   status;
	oele_pkg::entry_t    cell_data [D];
	logic [D:0]          seen;
	logic [D-1:0]        sel;
	oele_pkg::entry_t    pick_data;
	logic [oele_pkg::FP_W-1:0] pick_idx;
	logic                m_tvalid_q;
	logic [71:0]         m_tdata_q;

	assign key.kind = oele_pkg::req_t'(s_tdata[2:0]);
	assign key.pos = s_tdata[7:3];
	assign key.val = oele_pkg::entry_t'(s_tdata[63:8]);

	assign accept = s_tvalid && s_tready;
	assign commit = (state_q == oele_pkg::S_EVAL) && (!m_tvalid_q || m_tready);

	// Control state machine.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oele_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		case (state_q)
			oele_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = oele_pkg::S_EVAL;
				end
			end
			oele_pkg::S_EVAL: begin
				if (commit) begin
					state_d = oele_pkg::S_IDLE;
				end
			end
			default: state_d = oele_pkg::S_IDLE;
		endcase
	end

	// Request register.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= key;
		end
	end

	// Status, count update and which result fields carry meaning.
	always_comb begin
		status = oele_pkg::STS_BAD_POS;
		case (req_q.kind)
			oele_pkg::REQ_INSERT: begin
				if (count_q == oele_pkg::CNT_W'(D)) begin
					status = oele_pkg::STS_FULL;
				end else if (oele_pkg::CW'(req_q.pos) <= oele_pkg::CW'(count_q)) begin
					status = oele_pkg::STS_OK;
				end
			end
			oele_pkg::REQ_DELETE,
			oele_pkg::REQ_READ,
			oele_pkg::REQ_WRITE: begin
				if (oele_pkg::CW'(req_q.pos) < oele_pkg::CW'(count_q)) begin
					status = oele_pkg::STS_OK;
				end
			end
			oele_pkg::REQ_FIND_EXACT,
			oele_pkg::REQ_FIND_PICK,
			oele_pkg::REQ_FIND_DROP: begin
				status = seen[D] ? oele_pkg::STS_OK : oele_pkg::STS_NOT_FOUND;
			end
			default: status = oele_pkg::STS_BAD_POS;
		endcase
	end

	assign ok = status == oele_pkg::STS_OK;
	assign show_index = ok && ((req_q.kind == oele_pkg::REQ_FIND_EXACT) ||
		(req_q.kind == oele_pkg::REQ_FIND_PICK) || (req_q.kind == oele_pkg::REQ_FIND_DROP));
	assign show_entry = show_index || (ok && ((req_q.kind == oele_pkg::REQ_DELETE) ||
		(req_q.kind == oele_pkg::REQ_READ)));

	always_comb begin
		count_d = count_q;
		if (ok && (req_q.kind == oele_pkg::REQ_INSERT)) begin
			count_d = count_q + oele_pkg::CNT_W'(1);
		end else if (ok && (req_q.kind == oele_pkg::REQ_DELETE)) begin
			count_d = count_q - oele_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit) begin
			count_q <= count_d;
		end
	end

	// Broadcast update command.
	assign ctl.upd = commit && ok && ((req_q.kind == oele_pkg::REQ_INSERT) ||
		(req_q.kind == oele_pkg::REQ_DELETE) || (req_q.kind == oele_pkg::REQ_WRITE));
	assign ctl.req = req_q;

	// Cell chain; the search flag runs from cell 0 upward.
	assign seen[0] = 1'b0;
	for (genvar i = 0; i < D; i++) begin : g_cell
		oele_pkg::entry_t left_in;
		oele_pkg::entry_t right_in;
		if (i == 0) begin : g_first
			assign left_in = req_q.val;
		end else begin : g_mid
			assign left_in = cell_data[i-1];
		end
		if (i == D - 1) begin : g_last
			assign right_in = '0;
		end else begin : g_inner
			assign right_in = cell_data[i+1];
		end
		oele_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (oele_pkg::IDX_W'(i)),
			.count      (count_q),
			.key_load   (accept),
			.key        (key),
			.ctl        (ctl),
			.left_data  (left_in),
			.right_data (right_in),
			.seen_in    (seen[i]),
			.data       (cell_data[i]),
			.seen_out   (seen[i+1]),
			.sel        (sel[i])
		);
	end

	// One-hot select of the picked cell and its index.
	always_comb begin
		pick_data = '0;
		pick_idx = '0;
		for (int i = 0; i < D; i++) begin
			if (sel[i]) begin
				pick_data = pick_data | cell_data[i];
				pick_idx = pick_idx | oele_pkg::FP_W'(i);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_tdata_q <= {5'd0, oele_pkg::LEN_W'(count_d),
				show_entry ? pick_data : oele_pkg::entry_t'('0),
				show_index ? pick_idx : oele_pkg::FP_W'(0), status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	// The entry count never passes the list depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		oele_pkg::CW'(count_q) <= oele_pkg::CW'(D))
		else $error("entry count beyond depth");

	// An accepted request is always evaluated in the next cycle.
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == oele_pkg::S_EVAL))
		else $error("accepted request not evaluated");

	// A commit always leaves a result in the output register.
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_tvalid_q)
		else $error("commit without result");

	// At most one cell is picked while a request is evaluated.
	a_one_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == oele_pkg::S_EVAL) |-> $onehot0(sel))
		else $error("more than one cell picked");

endmodule
